### src/csf_pkg.sv
// Shared types and constants for the CSI colour sequence filter.
package csf_pkg;

    localparam int CP_W        = 21;
    localparam int SEQ_MAX_DEF = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 1'b1;

    localparam logic [CP_W-1:0] CP_BS       = CP_W'(8);
    localparam logic [CP_W-1:0] CP_TAB      = CP_W'(9);
    localparam logic [CP_W-1:0] CP_LF       = CP_W'(10);
    localparam logic [CP_W-1:0] CP_ESC      = CP_W'(27);
    localparam logic [CP_W-1:0] CP_CTRL_LIM = CP_W'(32);
    localparam logic [CP_W-1:0] CP_ZERO     = CP_W'(48);
    localparam logic [CP_W-1:0] CP_NINE     = CP_W'(57);
    localparam logic [CP_W-1:0] CP_COLON    = CP_W'(58);
    localparam logic [CP_W-1:0] CP_SEMI     = CP_W'(59);
    localparam logic [CP_W-1:0] CP_QUEST    = CP_W'(63);
    localparam logic [CP_W-1:0] CP_AT       = CP_W'(64);
    localparam logic [CP_W-1:0] CP_LBR      = CP_W'(91);
    localparam logic [CP_W-1:0] CP_CARET    = CP_W'(94);
    localparam logic [CP_W-1:0] CP_M        = CP_W'(109);

    typedef enum logic [2:0] {
        PS_NONE  = 3'b001,
        PS_ESC   = 3'b010,
        PS_PARAM = 3'b100
    } t_pstate;

    typedef enum logic [1:0] {
        TL_NONE  = 2'd0,
        TL_RAW   = 2'd1,
        TL_CARET = 2'd2
    } t_tail;

    typedef enum logic [1:0] {
        LN_KEEP  = 2'd0,
        LN_CLEAR = 2'd1,
        LN_INC   = 2'd2,
        LN_ONE   = 2'd3
    } t_len_op;

    // What one accepted code point does to the parser and what it emits.
    typedef struct packed {
        logic    we;
        logic    wr_zero;
        logic    head;
        logic    rep_all;
        logic    rep_plus1;
        logic    rep_esc;
        t_tail   tail;
        t_len_op len_op;
        t_pstate nx_state;
        logic    set_color;
    } t_plan;

endpackage

### src/csf_buf.sv
// Pending sequence store: one write port, one registered read port.
module csf_buf
    import csf_pkg::*;
#(
    parameter int DEPTH = SEQ_MAX_DEF,
    parameter int IDX_W = $clog2(SEQ_MAX_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [CP_W-1:0]  i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [CP_W-1:0]  o_rdata
);

    logic [CP_W-1:0] r_mem [DEPTH];
    logic [CP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/csf_caret.sv
// Shared emit unit: caret pairs for most control codes, one half per transfer.
module csf_caret
    import csf_pkg::*;
(
    input  logic [CP_W-1:0] i_cp,
    input  logic            i_esc_en,
    input  logic            i_bs_pass,
    input  logic            i_half,
    output logic [CP_W-1:0] o_cp,
    output logic            o_two
);

    logic shown;

    always_comb begin
        shown = (i_cp < CP_CTRL_LIM) && (i_cp != CP_TAB) && (i_cp != CP_LF);
        if (i_cp == CP_BS && i_bs_pass) begin
            shown = 1'b0;
        end
        o_two = i_esc_en && shown;
        if (!o_two) begin
            o_cp = i_cp;
        end else if (i_half) begin
            o_cp = CP_AT + i_cp;
        end else begin
            o_cp = CP_CARET;
        end
    end

endmodule

### src/csf_plan.sv
// Parser decision: next parser state, buffer write and emission plan for one code point.
module csf_plan
    import csf_pkg::*;
(
    input  logic [CP_W-1:0] i_cp,
    input  t_pstate         i_pstate,
    input  logic            i_full,
    input  logic            i_raw,
    input  logic            i_color,
    output t_plan           o_plan
);

    logic is_param;

    always_comb begin
        is_param = ((i_cp >= CP_ZERO) && (i_cp <= CP_NINE)) || (i_cp == CP_SEMI)
                   || (i_cp == CP_COLON) || (i_cp == CP_QUEST);

        o_plan           = '0;
        o_plan.tail      = TL_NONE;
        o_plan.len_op    = LN_KEEP;
        o_plan.nx_state  = PS_NONE;

        if (i_cp == CP_ESC && (i_raw || i_color)
            && i_pstate != PS_ESC && i_pstate != PS_PARAM) begin
            o_plan.nx_state = PS_ESC;
            if (i_raw) begin
                o_plan.tail   = TL_RAW;
                o_plan.len_op = LN_CLEAR;
            end else begin
                o_plan.we      = 1'b1;
                o_plan.wr_zero = 1'b1;
                o_plan.len_op  = LN_ONE;
            end
        end else if (i_pstate == PS_ESC) begin
            if (i_cp == CP_LBR) begin
                // an overflow here still leaves the parser in the parameter state
                o_plan.nx_state = PS_PARAM;
                if (i_raw) begin
                    o_plan.tail = TL_RAW;
                end else if (i_full) begin
                    o_plan.rep_all = 1'b1;
                    o_plan.rep_esc = 1'b1;
                    o_plan.tail    = TL_CARET;
                    o_plan.len_op  = LN_CLEAR;
                end else begin
                    o_plan.we     = 1'b1;
                    o_plan.len_op = LN_INC;
                end
            end else begin
                o_plan.rep_all = 1'b1;
                o_plan.rep_esc = 1'b1;
                o_plan.tail    = TL_CARET;
                o_plan.len_op  = LN_CLEAR;
            end
        end else if (i_pstate == PS_PARAM) begin
            if (is_param) begin
                if (i_raw) begin
                    o_plan.tail     = TL_RAW;
                    o_plan.nx_state = PS_PARAM;
                end else if (i_full) begin
                    o_plan.rep_all = 1'b1;
                    o_plan.rep_esc = 1'b1;
                    o_plan.tail    = TL_CARET;
                    o_plan.len_op  = LN_CLEAR;
                end else begin
                    o_plan.we       = 1'b1;
                    o_plan.len_op   = LN_INC;
                    o_plan.nx_state = PS_PARAM;
                end
            end else if (i_raw) begin
                // final char goes out first, then whatever was held before raw mode
                o_plan.head      = 1'b1;
                o_plan.rep_all   = 1'b1;
                o_plan.len_op    = LN_CLEAR;
                o_plan.set_color = (i_cp == CP_M);
            end else if (i_full) begin
                o_plan.rep_all = 1'b1;
                o_plan.rep_esc = 1'b1;
                o_plan.tail    = TL_CARET;
                o_plan.len_op  = LN_CLEAR;
            end else begin
                o_plan.we        = 1'b1;
                o_plan.rep_plus1 = 1'b1;
                o_plan.rep_esc   = (i_cp != CP_M);
                o_plan.set_color = (i_cp == CP_M);
                o_plan.len_op    = LN_CLEAR;
            end
        end else begin
            o_plan.tail = TL_CARET;
        end
    end

endmodule

### src/csi_color_sequence_filter_top.sv
// Top level of the CSI colour sequence filter: parser registers, buffer and emit sequencer.
//
// Input channel: i_valid / o_ready with i_code_point, one decoded code point per transfer.
// Output channel: o_valid / i_ready with o_out_code_point, o_last and o_color_seen.
// Each input transfer yields zero or more output transfers; o_last marks the final one.
// o_color_seen is the sticky colour flag as it stands after that input.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 raw mode, 1 colour mode) at once; write only while the block is idle.
// Sequencing: a code point that is only buffered produces no output. Otherwise
// the block accepts it, then emits each code point in turn, with a fetch
// state before each replayed buffer entry (registered read of the sequence
// store). A caret pair is two output transfers. Output is capped at SEQ_MAX+4
// transfers per input. o_ready is low from acceptance until the last transfer.
// A stalled receiver holds the current output steady; nothing is dropped.
// Reset: parser to none, buffer empty, colour flag and both modes cleared.
// Buffer contents are not cleared; only written entries are ever read.
module csi_color_sequence_filter_top
    import csf_pkg::*;
#(
    parameter int SEQ_MAX = SEQ_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CP_W-1:0]       i_code_point,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CP_W-1:0]       o_out_code_point,
    output logic                  o_last,
    output logic                  o_color_seen,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int LEN_W   = $clog2(SEQ_MAX + 1);
    localparam int IDX_W   = $clog2(SEQ_MAX);
    localparam int OUT_CAP = SEQ_MAX + 4;
    localparam int CNT_W   = $clog2(OUT_CAP + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HEAD  = 5'b00010,
        S_FETCH = 5'b00100,
        S_REP   = 5'b01000,
        S_TAIL  = 5'b10000
    } t_seq;

    t_seq             r_state, n_state;
    t_pstate          r_pstate, n_pstate;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_color, n_color;
    logic             r_raw;
    logic             r_color_mode;
    logic [CP_W-1:0]  r_c, n_c;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_rep_n, n_rep_n;
    logic             r_rep_esc, n_rep_esc;
    t_tail            r_tail, n_tail;
    logic             r_half, n_half;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    t_plan            plan;
    logic             full;
    logic             in_xfer;
    logic             out_xfer;
    logic [LEN_W-1:0] plan_rep_n;
    logic [IDX_W-1:0] waddr;
    logic [CP_W-1:0]  rd_data;
    logic [CP_W-1:0]  sel_cp;
    logic             esc_en;
    logic [CP_W-1:0]  cur_cp;
    logic             cur_two;
    logic             final_half;
    logic             rep_end;
    logic             nat_end;
    logic             cap_hit;

    assign full     = r_len >= LEN_W'(SEQ_MAX);
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_HEAD) || (r_state == S_REP) || (r_state == S_TAIL);
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    csf_plan u_plan (
        .i_cp     (i_code_point),
        .i_pstate (r_pstate),
        .i_full   (full),
        .i_raw    (r_raw),
        .i_color  (r_color_mode),
        .o_plan   (plan)
    );

    assign waddr = plan.wr_zero ? '0 : r_len[IDX_W-1:0];

    csf_buf #(
        .DEPTH (SEQ_MAX),
        .IDX_W (IDX_W)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (in_xfer && plan.we),
        .i_waddr (waddr),
        .i_wdata (i_code_point),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign sel_cp = (r_state == S_REP) ? rd_data : r_c;
    assign esc_en = (r_state == S_REP) ? r_rep_esc
                                       : ((r_state == S_TAIL) && (r_tail == TL_CARET));

    csf_caret u_caret (
        .i_cp      (sel_cp),
        .i_esc_en  (esc_en),
        .i_bs_pass (r_raw || r_color_mode),
        .i_half    (r_half),
        .o_cp      (cur_cp),
        .o_two     (cur_two)
    );

    assign final_half = !cur_two || r_half;
    assign rep_end    = (LEN_W'(r_idx) + LEN_W'(1)) == r_rep_n;
    assign cap_hit    = r_cnt == CNT_W'(OUT_CAP - 1);

    always_comb begin
        case (r_state)
            S_HEAD:  nat_end = (r_rep_n == '0) && (r_tail == TL_NONE);
            S_REP:   nat_end = rep_end && (r_tail == TL_NONE);
            S_TAIL:  nat_end = 1'b1;
            default: nat_end = 1'b0;
        endcase
    end

    assign o_out_code_point = cur_cp;
    assign o_last           = cap_hit || (final_half && nat_end);
    assign o_color_seen     = r_color;

    always_comb begin
        if (plan.rep_plus1) begin
            plan_rep_n = r_len + LEN_W'(1);
        end else if (plan.rep_all) begin
            plan_rep_n = r_len;
        end else begin
            plan_rep_n = '0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pstate  = r_pstate;
        n_len     = r_len;
        n_color   = r_color;
        n_c       = r_c;
        n_idx     = r_idx;
        n_rep_n   = r_rep_n;
        n_rep_esc = r_rep_esc;
        n_tail    = r_tail;
        n_half    = r_half;
        n_cnt     = r_cnt;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_c       = i_code_point;
                    n_cnt     = '0;
                    n_half    = 1'b0;
                    n_idx     = '0;
                    n_rep_n   = plan_rep_n;
                    n_rep_esc = plan.rep_esc;
                    n_tail    = plan.tail;
                    n_pstate  = plan.nx_state;
                    n_color   = r_color || plan.set_color;
                    case (plan.len_op)
                        LN_CLEAR: n_len = '0;
                        LN_INC:   n_len = r_len + LEN_W'(1);
                        LN_ONE:   n_len = LEN_W'(1);
                        default:  n_len = r_len;
                    endcase
                    if (plan.head) begin
                        n_state = S_HEAD;
                    end else if (plan_rep_n != '0) begin
                        n_state = S_FETCH;
                    end else if (plan.tail != TL_NONE) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_REP;
            end
            S_HEAD, S_REP, S_TAIL: begin
                if (out_xfer) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    if (cap_hit) begin
                        n_state = S_IDLE;
                    end else if (cur_two && !r_half) begin
                        n_half = 1'b1;
                    end else begin
                        n_half = 1'b0;
                        if (r_state == S_HEAD) begin
                            if (r_rep_n != '0) begin
                                n_state = S_FETCH;
                            end else if (r_tail != TL_NONE) begin
                                n_state = S_TAIL;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else if (r_state == S_REP && !rep_end) begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_state = S_FETCH;
                        end else if (r_state == S_REP && r_tail != TL_NONE) begin
                            n_state = S_TAIL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pstate     <= PS_NONE;
            r_len        <= '0;
            r_color      <= 1'b0;
            r_raw        <= 1'b0;
            r_color_mode <= 1'b0;
            r_cnt        <= '0;
            r_half       <= 1'b0;
            r_idx        <= '0;
            r_rep_n      <= '0;
            r_tail       <= TL_NONE;
        end else begin
            r_state  <= n_state;
            r_pstate <= n_pstate;
            r_len    <= n_len;
            r_color  <= n_color;
            r_cnt    <= n_cnt;
            r_half   <= n_half;
            r_idx    <= n_idx;
            r_rep_n  <= n_rep_n;
            r_tail   <= n_tail;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RAW:   r_raw        <= i_cfg_wdata[0];
                    CFG_COLOR: r_color_mode <= i_cfg_wdata[0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c       <= n_c;
        r_rep_esc <= n_rep_esc;
    end

    // buffer never holds more than its depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(SEQ_MAX))
        else $error("pending length beyond buffer depth");

    // replay index stays inside the entries being replayed
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REP) |-> (LEN_W'(r_idx) < r_rep_n))
        else $error("replay index past pending length");

    // a buffer read always lands in the replay state next
    a_fetch_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_REP))
        else $error("fetch not followed by replay");

    // the final transfer of an item returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after last transfer");

    // no transfer is issued beyond the per-item cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cnt < CNT_W'(OUT_CAP)))
        else $error("output count beyond cap");

endmodule

### dv/tb_csi_color_sequence_filter_top.sv
// Self-checking testbench for the CSI colour sequence filter top level.
`timescale 1ns / 100ps

module tb_csi_color_sequence_filter_top;
    import csf_pkg::*;

    localparam int SEQ_DEPTH = SEQ_MAX_DEF;
    localparam int OUT_LIMIT = SEQ_DEPTH + 4;

    localparam logic [CP_W-1:0] CP_LETTER_A = CP_W'(65);
    localparam logic [CP_W-1:0] CP_LETTER_J = CP_W'(74);
    localparam logic [CP_W-1:0] CP_LETTER_X = CP_W'(120);
    localparam logic [CP_W-1:0] CP_TOP      = CP_W'(21'h10FFFF);

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
        logic            seen;
    } due_char_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [CP_W-1:0]       i_code_point;
    logic                  o_valid;
    logic                  i_ready = 1'b1;
    logic [CP_W-1:0]       o_out_code_point;
    logic                  o_last;
    logic                  o_color_seen;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // filter state as seen from outside
    logic            flt_raw;
    logic            flt_colour;
    logic            flt_flag;
    t_pstate         flt_state;
    logic [CP_W-1:0] flt_buf [SEQ_DEPTH];
    int              flt_len;
    logic [CP_W-1:0] step_chars [$];
    due_char_t       due_chars [$];

    int idle_pct;
    int stall_pct;
    int faults;
    int code_points_sent;
    int transfers_checked;

    csi_color_sequence_filter_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_code_point     (i_code_point),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_code_point (o_out_code_point),
        .o_last           (o_last),
        .o_color_seen     (o_color_seen),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    function automatic void put(input logic [CP_W-1:0] c);
        if (step_chars.size() < OUT_LIMIT)
            step_chars.push_back(c);
    endfunction

    // control characters come out as caret pairs, except TAB, LF and (in a mode) BS
    function automatic void put_shown(input logic [CP_W-1:0] c);
        logic shown;
        shown = c < CP_CTRL_LIM && c != CP_TAB && c != CP_LF;
        if (c == CP_BS && (flt_raw || flt_colour))
            shown = 1'b0;
        if (shown) begin
            put(CP_CARET);
            put(CP_AT + c);
        end else begin
            put(c);
        end
    endfunction

    function automatic void replay_plain();
        for (int i = 0; i < flt_len; i++)
            put(flt_buf[i]);
        flt_len   = 0;
        flt_state = PS_NONE;
    endfunction

    function automatic void replay_shown();
        for (int i = 0; i < flt_len; i++)
            put_shown(flt_buf[i]);
        flt_len   = 0;
        flt_state = PS_NONE;
    endfunction

    function automatic void seq_push(input logic [CP_W-1:0] c);
        if (flt_raw) begin
            put(c);
        end else if (flt_len >= SEQ_DEPTH) begin
            replay_shown();
            put_shown(c);
        end else begin
            flt_buf[flt_len] = c;
            flt_len++;
        end
    endfunction

    function automatic void seq_end(input logic [CP_W-1:0] c);
        seq_push(c);
        if (flt_state != PS_NONE) begin
            if (c == CP_M) begin
                flt_flag = 1'b1;
                replay_plain();
            end else if (!flt_raw) begin
                replay_shown();
            end else begin
                replay_plain();
            end
        end
    endfunction

    function automatic void filter_code_point(input logic [CP_W-1:0] c);
        due_char_t d;
        step_chars.delete();
        if (c == CP_ESC && (flt_raw || flt_colour) && flt_state == PS_NONE) begin
            flt_len = 0;
            seq_push(c);
            flt_state = PS_ESC;
        end else if (flt_state == PS_ESC) begin
            if (c == CP_LBR) begin
                seq_push(c);
                flt_state = PS_PARAM;
            end else begin
                replay_shown();
                put_shown(c);
            end
        end else if (flt_state == PS_PARAM) begin
            if ((c >= CP_ZERO && c <= CP_NINE) || c == CP_SEMI || c == CP_COLON ||
                c == CP_QUEST)
                seq_push(c);
            else
                seq_end(c);
        end else begin
            put_shown(c);
        end
        for (int k = 0; k < step_chars.size(); k++) begin
            d.cp   = step_chars[k];
            d.last = (k == step_chars.size() - 1);
            d.seen = flt_flag;
            due_chars.push_back(d);
        end
    endfunction

    // input side first, so a code point's output is queued before it can be seen
    always @(posedge i_clk) begin
        due_char_t want;
        if (!i_rst_n) begin
            flt_raw    = 1'b0;
            flt_colour = 1'b0;
            flt_flag   = 1'b0;
            flt_state  = PS_NONE;
            flt_len    = 0;
            due_chars.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RAW:   flt_raw    = i_cfg_wdata[0];
                    CFG_COLOR: flt_colour = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready)
                filter_code_point(i_code_point);
            if (o_valid && i_ready) begin
                transfers_checked++;
                if (due_chars.size() == 0) begin
                    faults++;
                    $display("%0t: transfer with nothing due, actual cp %h last %b seen %b",
                             $time, o_out_code_point, o_last, o_color_seen);
                end else begin
                    want = due_chars.pop_front();
                    if (o_out_code_point !== want.cp) begin
                        faults++;
                        $display("%0t: out_code_point expected %h actual %h",
                                 $time, want.cp, o_out_code_point);
                    end
                    if (o_last !== want.last) begin
                        faults++;
                        $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                    end
                    if (o_color_seen !== want.seen) begin
                        faults++;
                        $display("%0t: color_seen expected %b actual %b",
                                 $time, want.seen, o_color_seen);
                    end
                end
            end
        end
    end

    task automatic send_code_point(input logic [CP_W-1:0] cp);
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < idle_pct);
        end
        i_valid      <= 1'b1;
        i_code_point <= cp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        code_points_sent++;
    endtask

    // hold off the sender until every owed transfer has gone out
    task automatic drain_filter();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_modes(input logic raw, input logic colour);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_RAW;
        i_cfg_wdata <= raw;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_COLOR;
        i_cfg_wdata <= colour;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [CP_W-1:0] any_code_point();
        int r;
        r = $urandom_range(99, 0);
        if (r < 35)
            return CP_W'($urandom_range(31, 0));
        else if (r < 60)
            return CP_W'($urandom_range(126, 32));
        else if (r < 80)
            return CP_W'($urandom_range(21'h10FFFF, 127));
        return CP_W'($urandom_range(21'h1FFFFF, 0));
    endfunction

    function automatic logic [CP_W-1:0] param_char();
        int r;
        r = $urandom_range(12, 0);
        if (r < 10)
            return CP_ZERO + CP_W'(r);
        else if (r == 10)
            return CP_SEMI;
        else if (r == 11)
            return CP_COLON;
        return CP_QUEST;
    endfunction

    function automatic logic [CP_W-1:0] closing_char();
        int r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return CP_M;
        else if (r < 80)
            return CP_W'($urandom_range(126, 64));
        return any_code_point();
    endfunction

    task automatic send_csi(input int n_params, input logic [CP_W-1:0] term_cp,
                            input bit switch_mid);
        send_code_point(CP_ESC);
        send_code_point(CP_LBR);
        for (int i = 0; i < n_params; i++) begin
            if (switch_mid && i == n_params / 2) begin
                drain_filter();
                write_modes(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end
            send_code_point(param_char());
        end
        send_code_point(term_cp);
    endtask

    task automatic run_mixed_traffic(input int n_items);
        int               start;
        int               kind;
        int               n_params;
        logic [CP_W-1:0]  c;
        start = code_points_sent;
        while (code_points_sent - start < n_items) begin
            kind = $urandom_range(99, 0);
            if (kind < 55) begin
                n_params = ($urandom_range(99, 0) < 8) ? $urandom_range(36, 28)
                                                       : $urandom_range(6, 0);
                send_csi(n_params, closing_char(), $urandom_range(9, 0) == 0);
            end else if (kind < 70) begin
                // ESC not followed by '['
                c = any_code_point();
                if (c == CP_LBR)
                    c = CP_AT;
                send_code_point(CP_ESC);
                send_code_point(c);
            end else begin
                send_code_point(any_code_point());
            end
        end
    endtask

    task automatic test_caret_plain();
        drain_filter();
        write_modes(1'b0, 1'b0);
        send_code_point(CP_W'(0));
        send_code_point(CP_BS);
        send_code_point(CP_TAB);
        send_code_point(CP_LF);
        send_code_point(CP_ESC);
        send_code_point(CP_CTRL_LIM - CP_W'(1));
        send_code_point(CP_CTRL_LIM);
        send_code_point(CP_LETTER_A);
        send_code_point(CP_TOP);
        send_code_point(CP_TOP + CP_W'(1));
        send_code_point(CP_W'(21'h1FFFFF));
    endtask

    task automatic test_colour_sequences();
        drain_filter();
        write_modes(1'b0, 1'b1);
        send_csi(0, CP_M, 1'b0);
        send_code_point(CP_ESC);
        send_code_point(CP_LBR);
        send_code_point(CP_ZERO + CP_W'(3));
        send_code_point(CP_ZERO + CP_W'(1));
        send_code_point(CP_M);
        send_csi(1, CP_LETTER_J, 1'b0);
        send_code_point(CP_ESC);
        send_code_point(CP_LETTER_X);
        send_code_point(CP_BS);
    endtask

    task automatic test_raw_passthrough();
        drain_filter();
        write_modes(1'b1, 1'b0);
        send_csi(1, CP_LETTER_J, 1'b0);
        send_code_point(CP_BS);
        send_code_point(CP_W'(1));
    endtask

    task automatic test_mode_switch_mid_sequence();
        drain_filter();
        write_modes(1'b0, 1'b1);
        send_code_point(CP_ESC);
        send_code_point(CP_LBR);
        send_code_point(CP_ZERO + CP_W'(1));
        drain_filter();
        write_modes(1'b1, 1'b1);
        send_code_point(CP_ZERO + CP_W'(2));
        send_code_point(CP_LETTER_J);
        send_code_point(CP_ESC);
        send_code_point(CP_LBR);
        drain_filter();
        write_modes(1'b0, 1'b1);
        send_code_point(CP_ZERO + CP_W'(5));
        send_code_point(CP_M);
    endtask

    // of three sequences, one overflows on a parameter, one on its closing character, one fits
    task automatic test_sequence_overflow();
        drain_filter();
        write_modes(1'b0, 1'b1);
        send_csi(SEQ_DEPTH - 1, CP_M, 1'b0);
        send_csi(SEQ_DEPTH - 2, CP_M, 1'b0);
        send_csi(SEQ_DEPTH - 3, CP_LETTER_J, 1'b0);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (int m = 0; m < 4; m++) begin
                drain_filter();
                write_modes(m[1], m[0]);
                run_mixed_traffic(8);
            end
        end
    endtask

    initial begin
        faults            = 0;
        code_points_sent  = 0;
        transfers_checked = 0;
        idle_pct          = 0;
        stall_pct         = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_code_point <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_RAW;
        i_cfg_wdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_caret_plain();
        test_colour_sequences();
        test_raw_passthrough();
        test_mode_switch_mid_sequence();
        idle_pct  = 21;
        stall_pct = 21;
        test_sequence_overflow();
        test_random_phases();
        drain_filter();

        $display("Sent %0d code points, checked %0d output transfers", code_points_sent,
                 transfers_checked);
        $display("Covered all four mode settings under four flow-control patterns");
        if (faults == 0)
            $display("csi_color_sequence_filter_top test passed");
        else
            $display("csi_color_sequence_filter_top test failed");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Timed out with %0d transfers still owed", due_chars.size());
        $display("csi_color_sequence_filter_top test failed");
        $finish;
    end

endmodule
